@@ rtl/core/ps2mc_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet cursor block.
// No dependencies; imported by ps2mc_in_reg, ps2mc_core and the top level.
package ps2mc_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 1024;
  localparam int DISPLAY_HEIGHT_DEF = 768;

  localparam int OUT_POS_W = 10;
  localparam int BTN_W     = 3;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [7:0] SYNC_MASK     = 8'h08;
  localparam logic [7:0] OVERFLOW_MASK = 8'hC0;
  localparam logic [7:0] BUTTON_MASK   = 8'h07;
  localparam int         X_SIGN_BIT    = 4;
  localparam int         Y_SIGN_BIT    = 5;

  typedef struct packed {
    logic       kind;
    logic       aux_flag;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] cursor_x;
    logic [OUT_POS_W-1:0] cursor_y;
    logic [BTN_W-1:0]     button_bits;
    logic                 updated;
    logic                 packet_done;
  } result_t;

endpackage

@@ rtl/core/ps2mc_in_reg.sv @@
// Input register stage: holds one accepted item for the decode stage.
// Depends on ps2mc_pkg for the item type.
module ps2mc_in_reg
  import ps2mc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/core/ps2mc_core.sv @@
// Packet assembly, cursor update and clamping; holds the decoder state.
// Depends on ps2mc_pkg for item and result types and byte masks.
module ps2mc_core
  import ps2mc_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
)
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  localparam int XW  = $clog2(DISPLAY_WIDTH);
  localparam int YW  = $clog2(DISPLAY_HEIGHT);
  localparam int AXW = ((XW > 9) ? XW : 9) + 2;
  localparam int AYW = ((YW > 9) ? YW : 9) + 2;
  localparam logic signed [AXW-1:0] X_LIM = AXW'(DISPLAY_WIDTH - 8);
  localparam logic signed [AYW-1:0] Y_LIM = AYW'(DISPLAY_HEIGHT - 12);

  typedef enum logic [1:0] {IDX_FIRST, IDX_SECOND, IDX_THIRD} idx_t;

  idx_t             idx_r, idx_nxt;
  logic [7:0]       hold0_r, hold0_nxt;
  logic [7:0]       hold1_r, hold1_nxt;
  logic [XW-1:0]    pos_x_r, pos_x_nxt;
  logic [YW-1:0]    pos_y_r, pos_y_nxt;
  logic [BTN_W-1:0] btn_r, btn_nxt;
  logic             mark_r, mark_nxt;
  logic             done;

  logic signed [8:0]     dx, dy;
  logic signed [AXW-1:0] sum_x;
  logic signed [AYW-1:0] sum_y;
  logic [XW-1:0]         clamp_x;
  logic [YW-1:0]         clamp_y;
  logic [31:0]           ext_x, ext_y;

  assign dx    = $signed({hold0_r[X_SIGN_BIT], hold1_r});
  assign dy    = $signed({hold0_r[Y_SIGN_BIT], item.data_byte});
  assign sum_x = AXW'($signed({1'b0, pos_x_r})) + AXW'(dx);
  assign sum_y = AYW'($signed({1'b0, pos_y_r})) - AYW'(dy);

  always_comb begin
    if (sum_x < 0) begin
      clamp_x = '0;
    end else if (sum_x > X_LIM) begin
      clamp_x = X_LIM[XW-1:0];
    end else begin
      clamp_x = sum_x[XW-1:0];
    end
    if (sum_y < 0) begin
      clamp_y = '0;
    end else if (sum_y > Y_LIM) begin
      clamp_y = Y_LIM[YW-1:0];
    end else begin
      clamp_y = sum_y[YW-1:0];
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    hold0_nxt = hold0_r;
    hold1_nxt = hold1_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    btn_nxt   = btn_r;
    mark_nxt  = mark_r;
    done      = 1'b0;
    if (item.kind == KIND_CLEAR) begin
      mark_nxt = 1'b0;
    end else if (item.aux_flag) begin
      case (idx_r)
        IDX_FIRST: begin
          if ((item.data_byte & SYNC_MASK) != '0) begin
            hold0_nxt = item.data_byte;
            idx_nxt   = IDX_SECOND;
          end
        end
        IDX_SECOND: begin
          hold1_nxt = item.data_byte;
          idx_nxt   = IDX_THIRD;
        end
        IDX_THIRD: begin
          idx_nxt = IDX_FIRST;
          if ((hold0_r & OVERFLOW_MASK) == '0) begin
            btn_nxt   = BTN_W'(hold0_r & BUTTON_MASK);
            pos_x_nxt = clamp_x;
            pos_y_nxt = clamp_y;
            mark_nxt  = 1'b1;
            done      = 1'b1;
          end
        end
        default: begin
          idx_nxt = IDX_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= IDX_FIRST;
      pos_x_r <= XW'(DISPLAY_WIDTH / 2);
      pos_y_r <= YW'(DISPLAY_HEIGHT / 2);
      btn_r   <= '0;
      mark_r  <= 1'b0;
    end else if (fire) begin
      idx_r   <= idx_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      btn_r   <= btn_nxt;
      mark_r  <= mark_nxt;
    end
    if (fire) begin
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
    end
  end

  assign ext_x = 32'(pos_x_nxt);
  assign ext_y = 32'(pos_y_nxt);

  assign result.cursor_x    = ext_x[OUT_POS_W-1:0];
  assign result.cursor_y    = ext_y[OUT_POS_W-1:0];
  assign result.button_bits = btn_nxt;
  assign result.updated     = mark_nxt;
  assign result.packet_done = done;

endmodule

@@ rtl/core/ps2_mouse_packet_cursor_top.sv @@
// PS/2 mouse packet decoder with clamped cursor: top level and result register.
// Depends on ps2mc_pkg, ps2mc_in_reg and ps2mc_core.
// Each item passes the input register, then the result register; while out_ready
// stalls a valid result, the item waits in the input register. Throughput: one
// item per cycle when not stalled, bounded by the single decode stage between
// those registers. Synchronous active-low reset returns the cursor to mid-screen,
// clears buttons, updated mark, packet position and valids.
module ps2_mouse_packet_cursor_top
  import ps2mc_pkg::*;
#(
  parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic                 in_aux_flag,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_POS_W-1:0] out_cursor_x,
  output logic [OUT_POS_W-1:0] out_cursor_y,
  output logic [BTN_W-1:0]     out_button_bits,
  output logic                 out_updated,
  output logic                 out_packet_done
);

  item_t   in_item, item;
  logic    item_valid;
  logic    out_load, fire;
  logic    out_valid_r, out_valid_nxt;
  result_t result, result_r;

  assign in_item.kind      = in_kind;
  assign in_item.aux_flag  = in_aux_flag;
  assign in_item.data_byte = in_data_byte;

  assign out_load = !out_valid_r || out_ready;
  assign fire     = item_valid && out_load;

  ps2mc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  ps2mc_core #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (fire) begin
      result_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_x    = result_r.cursor_x;
  assign out_cursor_y    = result_r.cursor_y;
  assign out_button_bits = result_r.button_bits;
  assign out_updated     = result_r.updated;
  assign out_packet_done = result_r.packet_done;

endmodule

@@ rtl/core/ps2mc_checker.sv @@
// Port-level checks for the PS/2 mouse packet cursor block, with its bind.
// Depends on the port list of ps2_mouse_packet_cursor_top.
module ps2mc_checker #(
  parameter int DISPLAY_WIDTH  = 1024,
  parameter int DISPLAY_HEIGHT = 768
)
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_cursor_x,
  input logic [9:0] out_cursor_y,
  input logic [2:0] out_button_bits,
  input logic       out_updated,
  input logic       out_packet_done
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_x) &&
      $stable(out_cursor_y) && $stable(out_button_bits) && $stable(out_updated) &&
      $stable(out_packet_done))
    else $error("stalled result changed");

  a_done_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_done |-> out_updated)
    else $error("applied packet without updated mark");

  a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (DISPLAY_WIDTH <= 1024) |-> 32'(out_cursor_x) <= DISPLAY_WIDTH - 8)
    else $error("cursor column beyond clamp");

  a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (DISPLAY_HEIGHT <= 1024) |-> 32'(out_cursor_y) <= DISPLAY_HEIGHT - 12)
    else $error("cursor row beyond clamp");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ps2_mouse_packet_cursor_top ps2mc_checker #(
  .DISPLAY_WIDTH  (DISPLAY_WIDTH),
  .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
) u_ps2mc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_cursor_x    (out_cursor_x),
  .out_cursor_y    (out_cursor_y),
  .out_button_bits (out_button_bits),
  .out_updated     (out_updated),
  .out_packet_done (out_packet_done)
);
